@@ rtl/core/tlsc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the traffic light state classifier.
package tlsc_pkg;

  localparam int LAMPS  = 3;
  localparam int SUM_W  = 32;
  localparam int CNT_W  = 24;
  localparam int MEAN_W = 16;
  localparam int BOX_W  = 64;
  localparam int DIM_W  = 16;

  // Frame queue between the accumulator and the divider.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [7:0]       OFF_LEVEL_RESET = 8'd80;

  typedef enum logic [2:0] {
    LS_OFF    = 3'd0,
    LS_RED    = 3'd1,
    LS_YELLOW = 3'd2,
    LS_GREEN  = 3'd3,
    LS_UNDEF  = 3'd4
  } light_state_t;

  typedef enum logic [2:0] {
    REG_RED_BOX    = 3'd0,
    REG_YELLOW_BOX = 3'd1,
    REG_GREEN_BOX  = 3'd2,
    REG_LAMP_COUNT = 3'd3,
    REG_OFF_LEVEL  = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_PREP,
    B_DIV,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [LAMPS-1:0][BOX_W-1:0] boxes;
    logic [1:0]                  lamp_count;
    logic [7:0]                  off_level;
  } cfg_t;

  typedef struct packed {
    logic [LAMPS-1:0][SUM_W-1:0] sums;
    logic [LAMPS-1:0][CNT_W-1:0] counts;
  } frame_acc_t;

  typedef struct packed {
    light_state_t                 state;
    logic [LAMPS-1:0][MEAN_W-1:0] means;
    logic [LAMPS-1:0]             lamps_valid;
  } result_t;

endpackage

@@ rtl/core/tlsc_front.sv @@
`timescale 1ns / 1ps
// Pixel front end: gray conversion, lamp box tests and per-frame accumulation.
module tlsc_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tlsc_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_BITS-1:0]  pix_x,
  input  logic [COORD_BITS-1:0]  pix_y,
  input  logic [7:0]             pix_red,
  input  logic [7:0]             pix_green,
  input  logic [7:0]             pix_blue,
  input  logic                   frame_end,
  output logic                   acc_push,
  output tlsc_pkg::frame_acc_t   acc_data,
  input  logic                   acc_full
);
  import tlsc_pkg::*;

  localparam int EDGE_W = DIM_W + 2;
  localparam int GRAY_W = 22;
  localparam logic [GRAY_W-1:0] WEIGHT_R = 22'd4899;
  localparam logic [GRAY_W-1:0] WEIGHT_G = 22'd9617;
  localparam logic [GRAY_W-1:0] WEIGHT_B = 22'd1868;
  localparam logic [GRAY_W-1:0] GRAY_RND = 22'd8192;

  // Inner half-box bounds, low edge inclusive and high edge exclusive.
  logic [LAMPS-1:0][EDGE_W-2:0] lo_x, lo_y;
  logic [LAMPS-1:0][EDGE_W-1:0] hi_x, hi_y;

  logic                  advance;
  logic                  p1_valid, p1_last;
  logic [COORD_BITS-1:0] p1_x, p1_y;
  logic [7:0]            p1_r, p1_g, p1_b;
  logic                  p2_valid, p2_last;
  logic [7:0]            p2_gray;
  logic [LAMPS-1:0]      p2_hit;

  logic [GRAY_W-1:0]     gray_wide;
  logic [LAMPS-1:0]      hit;
  logic [EDGE_W-1:0]     px_e, py_e;

  logic [LAMPS-1:0][SUM_W-1:0] sums, sums_next;
  logic [LAMPS-1:0][CNT_W-1:0] counts, counts_next;

  always_ff @(posedge clk) begin
    for (int i = 0; i < LAMPS; i++) begin
      lo_x[i] <= {1'b0, cfg.boxes[i][15:0]} + {3'b000, cfg.boxes[i][47:34]};
      lo_y[i] <= {1'b0, cfg.boxes[i][31:16]} + {3'b000, cfg.boxes[i][63:50]};
      hi_x[i] <= {2'b00, cfg.boxes[i][15:0]} + {4'b0000, cfg.boxes[i][47:34]}
                 + {3'b000, cfg.boxes[i][47:33]};
      hi_y[i] <= {2'b00, cfg.boxes[i][31:16]} + {4'b0000, cfg.boxes[i][63:50]}
                 + {3'b000, cfg.boxes[i][63:49]};
    end
  end

  // The whole pipe holds only while a frame end waits for queue space.
  assign advance  = !(p2_valid && p2_last && acc_full);
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else if (advance) begin
      p1_valid <= in_valid;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_x    <= pix_x;
      p1_y    <= pix_y;
      p1_r    <= pix_red;
      p1_g    <= pix_green;
      p1_b    <= pix_blue;
      p1_last <= frame_end;
      p2_gray <= gray_wide[21:14];
      p2_hit  <= hit;
      p2_last <= p1_last;
    end
  end

  always_comb begin
    gray_wide = {14'd0, p1_r} * WEIGHT_R + {14'd0, p1_g} * WEIGHT_G
                + {14'd0, p1_b} * WEIGHT_B + GRAY_RND;
    px_e = {{(EDGE_W-COORD_BITS){1'b0}}, p1_x};
    py_e = {{(EDGE_W-COORD_BITS){1'b0}}, p1_y};
    for (int i = 0; i < LAMPS; i++) begin
      hit[i] = (2'(i) < cfg.lamp_count)
               && (px_e >= {1'b0, lo_x[i]}) && (px_e < hi_x[i])
               && (py_e >= {1'b0, lo_y[i]}) && (py_e < hi_y[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < LAMPS; i++) begin
      if (p2_hit[i] && (counts[i] != COUNT_MAX)) begin
        sums_next[i]   = sums[i] + {24'd0, p2_gray};
        counts_next[i] = counts[i] + 24'd1;
      end else begin
        sums_next[i]   = sums[i];
        counts_next[i] = counts[i];
      end
    end
  end

  // The frame end pixel is counted before its totals are handed on.
  assign acc_push        = advance && p2_valid && p2_last;
  assign acc_data.sums   = sums_next;
  assign acc_data.counts = counts_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sums   <= '0;
      counts <= '0;
    end else if (advance && p2_valid) begin
      if (p2_last) begin
        sums   <= '0;
        counts <= '0;
      end else begin
        sums   <= sums_next;
        counts <= counts_next;
      end
    end
  end

endmodule

@@ rtl/core/tlsc_queue.sv @@
`timescale 1ns / 1ps
// Short queue of finished frame totals between the front end and the divider.
module tlsc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tlsc_pkg::frame_acc_t push_data,
  output logic                 full,
  input  logic                 pop,
  output tlsc_pkg::frame_acc_t head,
  output logic                 empty
);
  import tlsc_pkg::*;

  frame_acc_t                 entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]         wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0]         fill;
  logic                       do_push, do_pop;

  assign full    = (fill == Q_CNT_W'(Q_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/tlsc_back.sv @@
`timescale 1ns / 1ps
// Back end: per-lamp mean by a shared serial divider, state decision, result register.
module tlsc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  tlsc_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  tlsc_pkg::frame_acc_t q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tlsc_pkg::result_t    out_result
);
  import tlsc_pkg::*;

  localparam int DVD_W = SUM_W + 8;
  localparam logic [1:0] LAST_LAMP = 2'(LAMPS - 1);
  localparam logic [3:0] DIV_LAST  = 4'(MEAN_W - 1);
  localparam logic signed [MEAN_W:0] ABSENT_MEAN = -17'sd256;

  back_state_t                  state, state_next;
  frame_acc_t                   work;
  logic [1:0]                   lamp;
  logic [3:0]                   bit_cnt;
  logic [CNT_W-1:0]             rem, rem_next;
  logic [MEAN_W-1:0]            quo, quo_next;
  logic [LAMPS-1:0][MEAN_W-1:0] means;
  logic [LAMPS-1:0]             lamp_ok;

  logic                         active, load_out;
  logic [CNT_W-1:0]             div_n;
  logic [DVD_W-1:0]             dividend;
  logic [CNT_W:0]               trial;
  logic                         ge;
  logic signed [MEAN_W:0]       mv [LAMPS];
  logic signed [MEAN_W:0]       lvl;
  light_state_t                 decision;

  assign div_n    = work.counts[lamp];
  assign active   = (lamp < cfg.lamp_count) && (div_n != '0);
  // Rounded mean: (sum * 256 + count / 2) / count.
  assign dividend = {work.sums[lamp], 8'd0} + {16'd0, 1'b0, div_n[CNT_W-1:1]};

  // One restoring step; the quotient bits shift in behind the dividend bits.
  always_comb begin
    trial    = {rem, quo[MEAN_W-1]};
    ge       = (trial >= {1'b0, div_n});
    rem_next = ge ? CNT_W'(trial - {1'b0, div_n}) : trial[CNT_W-1:0];
    quo_next = {quo[MEAN_W-2:0], ge};
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = B_PREP;
        end
      end
      B_PREP: begin
        if (active) begin
          state_next = B_DIV;
        end else if (lamp == LAST_LAMP) begin
          state_next = B_DONE;
        end
      end
      B_DIV: begin
        if (bit_cnt == DIV_LAST) begin
          state_next = (lamp == LAST_LAMP) ? B_DONE : B_PREP;
        end
      end
      B_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          work <= q_head;
          lamp <= '0;
        end
      end
      B_PREP: begin
        if (active) begin
          rem     <= dividend[DVD_W-1:MEAN_W];
          quo     <= dividend[MEAN_W-1:0];
          bit_cnt <= '0;
        end else begin
          means[lamp]   <= '0;
          lamp_ok[lamp] <= 1'b0;
          lamp          <= lamp + 2'd1;
        end
      end
      B_DIV: begin
        rem     <= rem_next;
        quo     <= quo_next;
        bit_cnt <= bit_cnt + 4'd1;
        if (bit_cnt == DIV_LAST) begin
          means[lamp]   <= quo_next;
          lamp_ok[lamp] <= 1'b1;
          lamp          <= lamp + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // A lamp without a measurement ranks as -1.0 in every comparison.
  always_comb begin
    for (int i = 0; i < LAMPS; i++) begin
      mv[i] = lamp_ok[i] ? $signed({1'b0, means[i]}) : ABSENT_MEAN;
    end
    lvl = $signed({1'b0, cfg.off_level, 8'd0});
    if (cfg.lamp_count == '0) begin
      decision = LS_UNDEF;
    end else if ((mv[0] < lvl) && (mv[1] < lvl) && (mv[2] < lvl)) begin
      decision = LS_OFF;
    end else if ((mv[0] > mv[1]) && (mv[0] > mv[2])) begin
      decision = LS_RED;
    end else if ((mv[1] > mv[0]) && (mv[1] > mv[2])) begin
      decision = LS_YELLOW;
    end else if ((mv[2] > mv[0]) && (mv[2] > mv[1])) begin
      decision = LS_GREEN;
    end else begin
      decision = LS_UNDEF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_result.state       <= decision;
      out_result.means       <= means;
      out_result.lamps_valid <= lamp_ok;
    end
  end

endmodule

@@ rtl/core/traffic_light_state_classifier.sv @@
`timescale 1ns / 1ps
// Top level of the traffic light state classifier with its register port.
//
//  Channel   Direction  Handshake          Carries
//  s_*       in         tvalid / tready    one pixel per transaction, tlast = frame end
//  m_*       out        tvalid / tready    one light state and three lamp means per frame
//  APB       in / out   psel / penable     lamp boxes, lamp count, off level
//
// Pixels are taken at one per clock with no gaps while s_tready is high. A pixel
// passes the p1 and p2 registers of the front end before it lands in the lamp sums;
// the frame end pixel then moves the frame totals into a two-entry queue. The back
// end runs one serial divide per measured lamp plus a setup step per lamp. Synchronous
// reset clears the sums, the queue and both handshakes; there is no clearing pass.
// s_tready drops only while a frame end waits for a free queue entry, which takes two
// frames still waiting on the back end.
module traffic_light_state_classifier #(
  parameter int COORD_BITS = 12
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // pix_x, pix_y, pix_red, pix_green, pix_blue, then zero fill
  input  logic [((2*COORD_BITS+24+7)/8)*8-1:0]        s_tdata,
  input  logic                                        s_tlast,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // light_state, red_mean, yellow_mean, green_mean, then zero fill
  output logic [55:0]                                 m_tdata,
  // lamps_valid
  output logic [2:0]                                  m_tuser,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [5:0]                                  paddr,
  input  logic [63:0]                                 pwdata,
  output logic [63:0]                                 prdata,
  output logic                                        pready
);
  import tlsc_pkg::*;

  cfg_t       cfg;
  logic       reg_write;
  logic [2:0] reg_index;

  logic       acc_push, acc_full, acc_empty, acc_pop;
  frame_acc_t acc_data, acc_head;
  result_t    result;

  // Registers sit at byte address 8 * index.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boxes      <= '0;
      cfg.lamp_count <= '0;
      cfg.off_level  <= OFF_LEVEL_RESET;
    end else if (reg_write) begin
      case (reg_index)
        REG_RED_BOX:    cfg.boxes[0]   <= pwdata;
        REG_YELLOW_BOX: cfg.boxes[1]   <= pwdata;
        REG_GREEN_BOX:  cfg.boxes[2]   <= pwdata;
        REG_LAMP_COUNT: cfg.lamp_count <= pwdata[1:0];
        REG_OFF_LEVEL:  cfg.off_level  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_RED_BOX:    prdata = cfg.boxes[0];
      REG_YELLOW_BOX: prdata = cfg.boxes[1];
      REG_GREEN_BOX:  prdata = cfg.boxes[2];
      REG_LAMP_COUNT: prdata = {62'd0, cfg.lamp_count};
      REG_OFF_LEVEL:  prdata = {56'd0, cfg.off_level};
      default:        prdata = '0;
    endcase
  end

  // The front end sums gray values per lamp for the running frame.
  tlsc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .pix_x     (s_tdata[COORD_BITS-1:0]),
    .pix_y     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .pix_red   (s_tdata[2*COORD_BITS+7:2*COORD_BITS]),
    .pix_green (s_tdata[2*COORD_BITS+15:2*COORD_BITS+8]),
    .pix_blue  (s_tdata[2*COORD_BITS+23:2*COORD_BITS+16]),
    .frame_end (s_tlast),
    .acc_push  (acc_push),
    .acc_data  (acc_data),
    .acc_full  (acc_full)
  );

  // Finished frames wait here so the pixel stream waits on the divider only when the queue is full.
  tlsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (acc_push),
    .push_data (acc_data),
    .full      (acc_full),
    .pop       (acc_pop),
    .head      (acc_head),
    .empty     (acc_empty)
  );

  // The back end turns frame totals into means and a light state.
  tlsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (acc_empty),
    .q_head     (acc_head),
    .q_pop      (acc_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {5'd0, result.means[2], result.means[1], result.means[0], result.state};
  assign m_tuser = result.lamps_valid;

  // A frame end is only handed to the queue when it has room.
  assert property (@(posedge clk) disable iff (rst) !(acc_push && acc_full))
    else $error("frame totals pushed into a full queue");

  // The pixel side only stalls because the queue is full.
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> acc_full)
    else $error("pixel input stalled with queue space free");

  // With no lamp measured, the state can only be off or undefined.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (result.lamps_valid == 3'b000))
      |-> ((result.state == LS_OFF) || (result.state == LS_UNDEF)))
    else $error("lamp chosen although no lamp was measured");

  // A winning lamp must itself have been measured.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((result.state != LS_RED || result.lamps_valid[0])
               && (result.state != LS_YELLOW || result.lamps_valid[1])
               && (result.state != LS_GREEN || result.lamps_valid[2])))
    else $error("winning lamp has no measured mean");

endmodule
